// File: rtl/bmhq_pkg.sv
`timescale 1ns / 1ps

package bmhq_pkg;

	localparam int DEPTH   = 1024;
	localparam int VALUE_W = 32;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		OP_PUSH = 2'd0,
		OP_POP  = 2'd1,
		OP_FIND = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef struct packed {
		op_t                        op;
		logic signed [VALUE_W-1:0]  value;
	} req_t;

	typedef struct packed {
		status_t                    status;
		logic [ADDR_W-1:0]          found_index;
		logic signed [VALUE_W-1:0]  top_value;
		logic [CNT_W-1:0]           count;
	} rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_UP_CHK,
		S_UP_CMP,
		S_POP_LAST,
		S_DN_CHK,
		S_DN_L,
		S_DN_CMP,
		S_FIND_RD,
		S_FIND_CMP,
		S_DONE
	} ctl_state_t;

	typedef enum logic [4:0] {
		CMD_NOP,
		CMD_ACCEPT,
		CMD_SET_FULL,
		CMD_SET_EMPTY,
		CMD_SET_NF,
		CMD_PUSH_INIT,
		CMD_POP_INIT,
		CMD_POP_LOAD,
		CMD_UP_RD,
		CMD_UP_MOVE,
		CMD_PLACE,
		CMD_RD_L,
		CMD_LATCH_L,
		CMD_DN_MOVE,
		CMD_FIND_INIT,
		CMD_FIND_READ,
		CMD_FIND_STEP,
		CMD_FIND_HIT,
		CMD_EMIT
	} dp_cmd_t;

	typedef struct packed {
		op_t  op;
		logic full;
		logic empty;
		logic key_above;
		logic pos_zero;
		logic parent_lt;
		logic l_valid;
		logic dn_move;
		logic scan_end;
		logic hit;
		logic out_free;
	} dp_stat_t;

endpackage

// File: rtl/binary_max_heap_queue.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                Payload
// req       in         req_valid / req_ready    bmhq_pkg::req_t (op, value)
// rsp       out        rsp_valid / rsp_ready    bmhq_pkg::rsp_t (status, found_index,
//                                               top_value, count)
//
// One item is worked on at a time over a single-port-read heap RAM with registered reads.
// A push climbs the heap level by level and a pop descends it (at most 10 levels at 1024
// entries), and a find scans the entries one by one from index 0.
// The result sits in an output register; the next item is taken while it waits there.
// Reset empties the heap at once; RAM contents are not cleared.
// A stalled rsp channel holds the block in its final step until the output register frees.

module binary_max_heap_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  bmhq_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output bmhq_pkg::rsp_t  rsp
);

	bmhq_pkg::dp_cmd_t  cmd;
	bmhq_pkg::dp_stat_t stat;

	bmhq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	bmhq_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.stat      (stat),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.count <= bmhq_pkg::CNT_W'(bmhq_pkg::DEPTH))
		else $error("count exceeds depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.count == '0 |-> rsp.top_value == '0)
		else $error("empty heap reports a nonzero top");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == bmhq_pkg::ST_FULL
			|-> rsp.count == bmhq_pkg::CNT_W'(bmhq_pkg::DEPTH))
		else $error("full status with room left");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == bmhq_pkg::ST_EMPTY |-> rsp.count == '0)
		else $error("empty status on a nonempty heap");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != bmhq_pkg::ST_OK |-> rsp.found_index == '0)
		else $error("found index set without a match");

endmodule

// File: rtl/bmhq_ram.sv
`timescale 1ns / 1ps

module bmhq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/bmhq_ctrl.sv
`timescale 1ns / 1ps

module bmhq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  bmhq_pkg::dp_stat_t  stat,
	output bmhq_pkg::dp_cmd_t   cmd
);

	bmhq_pkg::ctl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bmhq_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = bmhq_pkg::CMD_NOP;
		req_ready = 1'b0;
		unique case (state_q)
			bmhq_pkg::S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd     = bmhq_pkg::CMD_ACCEPT;
					state_d = bmhq_pkg::S_DISPATCH;
				end
			end
			bmhq_pkg::S_DISPATCH: begin
				unique case (stat.op)
					bmhq_pkg::OP_PUSH: begin
						if (stat.full) begin
							cmd     = bmhq_pkg::CMD_SET_FULL;
							state_d = bmhq_pkg::S_DONE;
						end else begin
							cmd     = bmhq_pkg::CMD_PUSH_INIT;
							state_d = bmhq_pkg::S_UP_CHK;
						end
					end
					bmhq_pkg::OP_POP: begin
						if (stat.empty) begin
							cmd     = bmhq_pkg::CMD_SET_EMPTY;
							state_d = bmhq_pkg::S_DONE;
						end else begin
							cmd     = bmhq_pkg::CMD_POP_INIT;
							state_d = bmhq_pkg::S_POP_LAST;
						end
					end
					bmhq_pkg::OP_FIND: begin
						if (stat.empty || stat.key_above) begin
							cmd     = bmhq_pkg::CMD_SET_NF;
							state_d = bmhq_pkg::S_DONE;
						end else begin
							cmd     = bmhq_pkg::CMD_FIND_INIT;
							state_d = bmhq_pkg::S_FIND_RD;
						end
					end
					default: begin
						state_d = bmhq_pkg::S_DONE;
					end
				endcase
			end
			bmhq_pkg::S_UP_CHK: begin
				if (stat.pos_zero) begin
					cmd     = bmhq_pkg::CMD_PLACE;
					state_d = bmhq_pkg::S_DONE;
				end else begin
					cmd     = bmhq_pkg::CMD_UP_RD;
					state_d = bmhq_pkg::S_UP_CMP;
				end
			end
			bmhq_pkg::S_UP_CMP: begin
				if (stat.parent_lt) begin
					cmd     = bmhq_pkg::CMD_UP_MOVE;
					state_d = bmhq_pkg::S_UP_CHK;
				end else begin
					cmd     = bmhq_pkg::CMD_PLACE;
					state_d = bmhq_pkg::S_DONE;
				end
			end
			bmhq_pkg::S_POP_LAST: begin
				cmd     = bmhq_pkg::CMD_POP_LOAD;
				state_d = bmhq_pkg::S_DN_CHK;
			end
			bmhq_pkg::S_DN_CHK: begin
				if (stat.l_valid) begin
					cmd     = bmhq_pkg::CMD_RD_L;
					state_d = bmhq_pkg::S_DN_L;
				end else begin
					cmd     = bmhq_pkg::CMD_PLACE;
					state_d = bmhq_pkg::S_DONE;
				end
			end
			bmhq_pkg::S_DN_L: begin
				cmd     = bmhq_pkg::CMD_LATCH_L;
				state_d = bmhq_pkg::S_DN_CMP;
			end
			bmhq_pkg::S_DN_CMP: begin
				if (stat.dn_move) begin
					cmd     = bmhq_pkg::CMD_DN_MOVE;
					state_d = bmhq_pkg::S_DN_CHK;
				end else begin
					cmd     = bmhq_pkg::CMD_PLACE;
					state_d = bmhq_pkg::S_DONE;
				end
			end
			bmhq_pkg::S_FIND_RD: begin
				if (stat.scan_end) begin
					state_d = bmhq_pkg::S_DONE;
				end else begin
					cmd     = bmhq_pkg::CMD_FIND_READ;
					state_d = bmhq_pkg::S_FIND_CMP;
				end
			end
			bmhq_pkg::S_FIND_CMP: begin
				if (stat.hit) begin
					cmd     = bmhq_pkg::CMD_FIND_HIT;
					state_d = bmhq_pkg::S_DONE;
				end else begin
					cmd     = bmhq_pkg::CMD_FIND_STEP;
					state_d = bmhq_pkg::S_FIND_RD;
				end
			end
			bmhq_pkg::S_DONE: begin
				if (stat.out_free) begin
					cmd     = bmhq_pkg::CMD_EMIT;
					state_d = bmhq_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = bmhq_pkg::S_IDLE;
			end
		endcase
	end

endmodule

// File: rtl/bmhq_datapath.sv
`timescale 1ns / 1ps

module bmhq_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  bmhq_pkg::req_t      req,
	input  bmhq_pkg::dp_cmd_t   cmd,
	output bmhq_pkg::dp_stat_t  stat,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output bmhq_pkg::rsp_t      rsp
);

	localparam int AW = bmhq_pkg::ADDR_W;
	localparam int CW = bmhq_pkg::CNT_W;
	localparam int VW = bmhq_pkg::VALUE_W;

	bmhq_pkg::op_t            op_q;
	logic signed [VW-1:0]     cur_q;
	logic signed [VW-1:0]     top_q;
	logic signed [VW-1:0]     left_q;
	logic [CW-1:0]            pos_q;
	logic [CW-1:0]            count_q;
	bmhq_pkg::status_t        status_q;
	logic [AW-1:0]            index_q;
	bmhq_pkg::rsp_t           out_q;
	logic                     out_valid_q;

	logic signed [VW-1:0]     rd_data;
	logic [VW-1:0]            rd_raw;
	logic                     we;
	logic                     re;
	logic [AW-1:0]            raddr;
	logic signed [VW-1:0]     wdata;
	logic [CW-1:0]            pos_m1;
	logic [CW-1:0]            parent;
	logic [CW-1:0]            count_m1;
	logic [CW:0]              l_idx;
	logic [CW:0]              r_idx;
	logic                     l_valid;
	logic                     r_valid;
	logic                     pick_r;
	logic signed [VW-1:0]     best_val;
	logic [CW-1:0]            best_idx;
	logic                     dn_move;
	logic                     out_free;

	assign rd_data  = $signed(rd_raw);
	assign pos_m1   = pos_q - CW'(1);
	assign parent   = pos_m1 >> 1;
	assign count_m1 = count_q - CW'(1);
	assign l_idx    = {pos_q, 1'b1};
	assign r_idx    = l_idx + (CW+1)'(1);
	assign l_valid  = l_idx < {1'b0, count_q};
	assign r_valid  = r_idx < {1'b0, count_q};

	// Ties between the two children go to the right child.
	assign pick_r   = r_valid && !(left_q > rd_data);
	assign best_val = pick_r ? rd_data : left_q;
	assign best_idx = pick_r ? r_idx[CW-1:0] : l_idx[CW-1:0];
	assign dn_move  = best_val > cur_q;
	assign out_free = !out_valid_q || rsp_ready;

	always_comb begin
		stat.op        = op_q;
		stat.full      = count_q == CW'(bmhq_pkg::DEPTH);
		stat.empty     = count_q == '0;
		stat.key_above = cur_q > top_q;
		stat.pos_zero  = pos_q == '0;
		stat.parent_lt = rd_data < cur_q;
		stat.l_valid   = l_valid;
		stat.dn_move   = dn_move;
		stat.scan_end  = pos_q == count_q;
		stat.hit       = rd_data == cur_q;
		stat.out_free  = out_free;
	end

	always_comb begin
		re    = 1'b0;
		raddr = pos_q[AW-1:0];
		we    = 1'b0;
		wdata = cur_q;
		unique case (cmd)
			bmhq_pkg::CMD_UP_RD: begin
				re    = 1'b1;
				raddr = parent[AW-1:0];
			end
			bmhq_pkg::CMD_POP_INIT: begin
				re    = 1'b1;
				raddr = count_m1[AW-1:0];
			end
			bmhq_pkg::CMD_RD_L: begin
				re    = 1'b1;
				raddr = l_idx[AW-1:0];
			end
			bmhq_pkg::CMD_LATCH_L: begin
				re    = r_valid;
				raddr = r_idx[AW-1:0];
			end
			bmhq_pkg::CMD_FIND_READ: begin
				re = 1'b1;
			end
			bmhq_pkg::CMD_PLACE: begin
				we = 1'b1;
			end
			bmhq_pkg::CMD_UP_MOVE: begin
				we    = 1'b1;
				wdata = rd_data;
			end
			bmhq_pkg::CMD_DN_MOVE: begin
				we    = 1'b1;
				wdata = best_val;
			end
			default: begin
				re = 1'b0;
			end
		endcase
	end

	bmhq_ram #(
		.WIDTH (VW),
		.DEPTH (bmhq_pkg::DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (pos_q[AW-1:0]),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rd_raw)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (cmd)
				bmhq_pkg::CMD_PUSH_INIT: count_q <= count_q + CW'(1);
				bmhq_pkg::CMD_POP_INIT:  count_q <= count_m1;
				default:                 count_q <= count_q;
			endcase
			if (cmd == bmhq_pkg::CMD_EMIT) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we && pos_q == '0) begin
			top_q <= wdata;
		end
		case (cmd)
			bmhq_pkg::CMD_ACCEPT: begin
				op_q     <= req.op;
				cur_q    <= req.value;
				status_q <= bmhq_pkg::ST_OK;
				index_q  <= '0;
			end
			bmhq_pkg::CMD_SET_FULL:  status_q <= bmhq_pkg::ST_FULL;
			bmhq_pkg::CMD_SET_EMPTY: status_q <= bmhq_pkg::ST_EMPTY;
			bmhq_pkg::CMD_SET_NF:    status_q <= bmhq_pkg::ST_NOT_FOUND;
			bmhq_pkg::CMD_PUSH_INIT: pos_q    <= count_q;
			bmhq_pkg::CMD_POP_INIT:  pos_q    <= '0;
			bmhq_pkg::CMD_POP_LOAD:  cur_q    <= rd_data;
			bmhq_pkg::CMD_UP_MOVE:   pos_q    <= parent;
			bmhq_pkg::CMD_LATCH_L:   left_q   <= rd_data;
			bmhq_pkg::CMD_DN_MOVE:   pos_q    <= best_idx;
			bmhq_pkg::CMD_FIND_INIT: begin
				pos_q    <= '0;
				status_q <= bmhq_pkg::ST_NOT_FOUND;
			end
			bmhq_pkg::CMD_FIND_STEP: pos_q <= pos_q + CW'(1);
			bmhq_pkg::CMD_FIND_HIT: begin
				status_q <= bmhq_pkg::ST_OK;
				index_q  <= pos_q[AW-1:0];
			end
			bmhq_pkg::CMD_EMIT: begin
				out_q.status      <= status_q;
				out_q.found_index <= index_q;
				out_q.top_value   <= (count_q == '0) ? '0 : top_q;
				out_q.count       <= count_q;
			end
			default: begin
				op_q <= op_q;
			end
		endcase
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

// File: bench/tb_binary_max_heap_queue.sv
`timescale 1ns / 1ps

module tb_binary_max_heap_queue;
	import bmhq_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int RANDOM_OPS = 550;
	localparam logic signed [VALUE_W-1:0] VMIN = {1'b1, {(VALUE_W-1){1'b0}}};
	localparam logic signed [VALUE_W-1:0] VMAX = {1'b0, {(VALUE_W-1){1'b1}}};
	localparam op_t OP_RSVD = op_t'(2'd3);

	typedef struct packed {
		op_t                       op;
		logic signed [VALUE_W-1:0] value;
		logic                      typed;
		rsp_t                      want;
	} dir_row_t;

	localparam int N_DIRECTED = 25;
	localparam dir_row_t DIRECTED_ROWS [N_DIRECTED] = '{
		'{OP_POP,   32'sd0,  1'b1, '{ST_EMPTY,     10'd0, 32'sd0, 11'd0}},
		'{OP_FIND,  32'sd0,  1'b1, '{ST_NOT_FOUND, 10'd0, 32'sd0, 11'd0}},
		'{OP_RSVD,  VMAX,    1'b1, '{ST_OK,        10'd0, 32'sd0, 11'd0}},
		'{OP_PUSH,  VMIN,    1'b1, '{ST_OK,        10'd0, VMIN,   11'd1}},
		'{OP_PUSH,  VMAX,    1'b1, '{ST_OK,        10'd0, VMAX,   11'd2}},
		'{OP_FIND,  VMIN,    1'b0, '0},
		'{OP_FIND,  VMAX,    1'b1, '{ST_OK,        10'd0, VMAX,   11'd2}},
		'{OP_POP,   32'sd0,  1'b1, '{ST_OK,        10'd0, VMIN,   11'd1}},
		'{OP_FIND,  VMAX,    1'b1, '{ST_NOT_FOUND, 10'd0, VMIN,   11'd1}},
		'{OP_POP,   32'sd0,  1'b1, '{ST_OK,        10'd0, 32'sd0, 11'd0}},
		'{OP_PUSH,  32'sd0,  1'b0, '0},
		'{OP_PUSH,  -32'sd1, 1'b0, '0},
		'{OP_PUSH,  32'sd5,  1'b0, '0},
		'{OP_PUSH,  32'sd5,  1'b0, '0},
		'{OP_PUSH,  32'sd3,  1'b0, '0},
		'{OP_PUSH,  32'sd5,  1'b0, '0},
		'{OP_FIND,  32'sd3,  1'b0, '0},
		'{OP_FIND,  32'sd4,  1'b0, '0},
		'{OP_FIND,  -32'sd1, 1'b0, '0},
		'{OP_RSVD,  -32'sd1, 1'b0, '0},
		'{OP_POP,   32'sd0,  1'b0, '0},
		'{OP_POP,   32'sd0,  1'b0, '0},
		'{OP_PUSH,  VMIN,    1'b0, '0},
		'{OP_POP,   32'sd0,  1'b0, '0},
		'{OP_POP,   32'sd0,  1'b0, '0}
	};

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	logic signed [VALUE_W-1:0] heap_model [DEPTH];
	int heap_size;
	int peak_size;
	rsp_t pending_results [$];
	rsp_t result_want;
	int err_count;
	int result_count;
	int cycle_count;
	int op_tally [4];
	int status_tally [4];
	bit sender_quiet;

	binary_max_heap_queue dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic rsp_t apply_heap_op(op_t op, logic signed [VALUE_W-1:0] v);
		rsp_t r;
		int pos;
		int parent;
		int l;
		int rc;
		int best;
		int i;
		bit done;
		logic signed [VALUE_W-1:0] t;
		r = '0;
		r.status = ST_OK;
		case (op)
			OP_PUSH: begin
				if (heap_size >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					heap_model[heap_size] = v;
					pos = heap_size;
					heap_size++;
					done = 1'b0;
					while (pos > 0 && !done) begin
						parent = (pos - 1) / 2;
						if (heap_model[parent] < heap_model[pos]) begin
							t = heap_model[parent];
							heap_model[parent] = heap_model[pos];
							heap_model[pos] = t;
							pos = parent;
						end else begin
							done = 1'b1;
						end
					end
				end
			end
			OP_POP: begin
				if (heap_size == 0) begin
					r.status = ST_EMPTY;
				end else begin
					heap_size--;
					heap_model[0] = heap_model[heap_size];
					pos = 0;
					done = 1'b0;
					while (!done) begin
						l = 2 * pos + 1;
						rc = l + 1;
						best = pos;
						if (rc < heap_size) begin
							if (heap_model[l] > heap_model[pos] || heap_model[rc] > heap_model[pos])
								best = (heap_model[l] > heap_model[rc]) ? l : rc;
						end else if (l < heap_size) begin
							if (heap_model[l] > heap_model[pos])
								best = l;
						end
						if (best == pos) begin
							done = 1'b1;
						end else begin
							t = heap_model[pos];
							heap_model[pos] = heap_model[best];
							heap_model[best] = t;
							pos = best;
						end
					end
				end
			end
			OP_FIND: begin
				r.status = ST_NOT_FOUND;
				if (heap_size > 0 && !(v > heap_model[0])) begin
					done = 1'b0;
					for (i = 0; i < heap_size && !done; i++) begin
						if (heap_model[i] == v) begin
							r.status = ST_OK;
							r.found_index = i[ADDR_W-1:0];
							done = 1'b1;
						end
					end
				end
			end
			default: begin
			end
		endcase
		r.top_value = (heap_size > 0) ? heap_model[0] : '0;
		r.count = heap_size[CNT_W-1:0];
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	function automatic logic signed [VALUE_W-1:0] rand_value();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return $signed(VALUE_W'($urandom_range(0, 15))) - 8;
		if (r == 4) begin
			case ($urandom_range(0, 3))
				0: return VMIN;
				1: return VMAX;
				2: return '0;
				default: return -1;
			endcase
		end
		return $signed(VALUE_W'($urandom));
	endfunction

	function automatic logic signed [VALUE_W-1:0] pick_find_key();
		int r;
		r = $urandom_range(0, 9);
		if (heap_size > 0 && r < 5)
			return heap_model[$urandom_range(0, heap_size - 1)];
		if (heap_size > 0 && r == 5 && heap_model[0] != VMAX)
			return heap_model[0] + 1;
		return rand_value();
	endfunction

	task automatic report_error(string msg);
		$display("ERROR: %s", msg);
		err_count++;
	endtask

	task automatic check_result(rsp_t got, rsp_t want);
		if (got.status !== want.status)
			report_error($sformatf("result %0d status: got %0d expected %0d",
				result_count, got.status, want.status));
		if (got.found_index !== want.found_index)
			report_error($sformatf("result %0d found_index: got %0d expected %0d",
				result_count, got.found_index, want.found_index));
		if (got.top_value !== want.top_value)
			report_error($sformatf("result %0d top_value: got %0d expected %0d",
				result_count, got.top_value, want.top_value));
		if (got.count !== want.count)
			report_error($sformatf("result %0d count: got %0d expected %0d",
				result_count, got.count, want.count));
	endtask

	task automatic send_item(op_t op, logic signed [VALUE_W-1:0] v, bit typed, rsp_t want);
		int gap;
		rsp_t predicted;
		gap = sender_quiet ? 0 : pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		req <= '{op, v};
		do @(posedge clk); while (!req_ready);
		predicted = apply_heap_op(op, v);
		pending_results.push_back(typed ? want : predicted);
		op_tally[op]++;
		status_tally[predicted.status]++;
		if (heap_size > peak_size)
			peak_size = heap_size;
		@(negedge clk);
	endtask

	task automatic drain_results();
		req_valid <= 1'b0;
		@(negedge clk);
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding.",
				cycle_count, pending_results.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_results.size() == 0) begin
				report_error($sformatf("result %0d arrived with no item outstanding",
					result_count));
			end else begin
				result_want = pending_results.pop_front();
				check_result(rsp, result_want);
			end
			result_count++;
		end
	end

	initial begin
		int run;
		int gap;
		rsp_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			run = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 40);
			rsp_ready <= 1'b1;
			repeat (run) @(negedge clk);
			gap = pick_gap();
			if (gap > 0) begin
				rsp_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
	end

	initial begin
		int i;
		int done_ops;
		int r;
		op_t op;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		heap_size = 0;
		peak_size = 0;
		err_count = 0;
		result_count = 0;
		cycle_count = 0;
		sender_quiet = 1'b0;
		for (i = 0; i < 4; i++) begin
			op_tally[i] = 0;
			status_tally[i] = 0;
		end
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (i = 0; i < N_DIRECTED; i++)
			send_item(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].value,
				DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
		drain_results();

		done_ops = 0;
		while (done_ops < RANDOM_OPS) begin
			if (done_ops % 50 == 0)
				sender_quiet = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 99);
			if (r < 3)
				op = OP_RSVD;
			else if (heap_size > 56)
				op = (r < 30) ? OP_PUSH : (r < 75) ? OP_POP : OP_FIND;
			else
				op = (r < 50) ? OP_PUSH : (r < 72) ? OP_POP : OP_FIND;
			send_item(op, (op == OP_FIND) ? pick_find_key() : rand_value(), 1'b0, '0);
			if (op != OP_RSVD)
				done_ops++;
			if ($urandom_range(0, 99) == 0) begin
				while (heap_size > 0) begin
					send_item(OP_POP, rand_value(), 1'b0, '0);
					done_ops++;
				end
				send_item(OP_POP, rand_value(), 1'b0, '0);
				done_ops++;
			end
			if ($urandom_range(0, 49) == 0)
				drain_results();
		end
		drain_results();

		sender_quiet = 1'b0;
		while (heap_size < DEPTH) begin
			send_item(OP_PUSH, rand_value(), 1'b0, '0);
			if ($urandom_range(0, 99) == 0)
				send_item(OP_FIND, pick_find_key(), 1'b0, '0);
		end
		send_item(OP_PUSH, rand_value(), 1'b0, '0);
		send_item(OP_FIND, heap_model[DEPTH - 1], 1'b0, '0);
		send_item(OP_FIND, pick_find_key(), 1'b0, '0);
		send_item(OP_FIND, rand_value(), 1'b0, '0);
		send_item(OP_RSVD, rand_value(), 1'b0, '0);
		while (heap_size > 0)
			send_item(OP_POP, rand_value(), 1'b0, '0);
		send_item(OP_POP, rand_value(), 1'b0, '0);
		drain_results();

		repeat (60) @(posedge clk);
		$display("Ran %0d pushes, %0d pops, %0d finds and %0d reserved-op items; peak depth %0d of %0d.",
			op_tally[OP_PUSH], op_tally[OP_POP], op_tally[OP_FIND], op_tally[OP_RSVD],
			peak_size, DEPTH);
		$display("Statuses seen: ok %0d, empty %0d, full %0d, not found %0d; %0d results checked.",
			status_tally[ST_OK], status_tally[ST_EMPTY], status_tally[ST_FULL],
			status_tally[ST_NOT_FOUND], result_count);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// File: filelist.f
rtl/bmhq_pkg.sv
rtl/bmhq_ram.sv
rtl/bmhq_ctrl.sv
rtl/bmhq_datapath.sv
rtl/binary_max_heap_queue.sv
bench/tb_binary_max_heap_queue.sv
